// ===== rtl/alle_pkg.sv =====
`default_nettype none

package alle_pkg;

  // request actions
  localparam logic [2:0] ACT_INS_BEFORE = 3'd0;
  localparam logic [2:0] ACT_INS_AFTER  = 3'd1;
  localparam logic [2:0] ACT_DELETE     = 3'd2;
  localparam logic [2:0] ACT_FIND       = 3'd3;
  localparam logic [2:0] ACT_DUMP       = 3'd4;

  // result status codes
  localparam logic [2:0] STAT_DONE      = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_EMPTY     = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_FOUND     = 3'd4;

  localparam int          VALUE_W   = 32;
  localparam int          TOTAL_W   = 4;
  localparam logic [3:0]  MAX_DUMP  = 4'd15;

endpackage

`default_nettype wire

// ===== rtl/alle_if.sv =====
`default_nettype none

interface alle_req_if;
  import alle_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [2:0]                action;
  logic signed [VALUE_W-1:0] key;
  logic signed [VALUE_W-1:0] new_value;

  modport source (output valid, action, key, new_value, input ready);
  modport sink   (input valid, action, key, new_value, output ready);
endinterface

interface alle_rsp_if;
  import alle_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic signed [VALUE_W-1:0] value;
  logic                      last;
  logic                      is_empty;
  logic                      is_full;
  logic [TOTAL_W-1:0]        element_total;

  modport source (output valid, status, value, last, is_empty, is_full, element_total,
                  input ready);
  modport sink   (input valid, status, value, last, is_empty, is_full, element_total,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/alle_ram.sv =====
`default_nettype none

module alle_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port (read returns old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/array_linked_list_engine.sv =====
// Array-backed singly linked list engine.
//
// Requests arrive on req_i (valid/ready): an action, a key and a new value.
// Results leave on rsp_o (valid/ready) through a single output register.
// Slot 0 is the head sentinel (kept in a flip-flop); values, links and
// slot-used bits live in three single-port-read RAMs of LIST_SLOTS entries.
//
// After reset the block sweeps the used-bit RAM, one entry a cycle, so
// req_i.ready stays low until the sweep is done. Then one request is processed
// at a time; ready is high only while the sequencer is idle.
// Steps per request, with n the elements walked:
//   find / delete : capture, n walk steps (one link read per cycle), response
//   insert        : as find, plus a free-slot scan of up to LIST_SLOTS - 1
//                   used-bit reads, then a link step
//   dump          : capture, then one emitted element per step (at most 15)
// A stalled receiver holds the output register; the sequencer waits in its
// response or dump state until the register frees up, and the pending
// result is never lost or repeated. The shared key comparator and the one
// read port of the link RAM set the walk rate.
`default_nettype none

module array_linked_list_engine
  import alle_pkg::*;
#(
  parameter int LIST_SLOTS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  alle_req_if.sink     req_i,
  alle_rsp_if.source   rsp_o
);

  localparam int             SW        = $clog2(LIST_SLOTS);
  localparam logic [SW-1:0]  LastSlot  = SW'(LIST_SLOTS - 1);
  localparam logic [SW-1:0]  FirstSlot = SW'(1);
  localparam logic [SW-1:0]  HeadSlot  = '0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_SCAN,
    S_LINK,
    S_DUMP,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  logic [SW-1:0]        clr_q, clr_d;
  logic [2:0]           action_q, action_d;
  logic [VALUE_W-1:0]   key_q, key_d;
  logic [VALUE_W-1:0]   nv_q, nv_d;
  logic [SW-1:0]        cur_q, cur_d;
  logic [SW-1:0]        prev_q, prev_d;
  logic [SW-1:0]        next_q, next_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic [SW-1:0]        head_q, head_d;
  logic [SW-1:0]        count_q, count_d;
  logic [3:0]           dump_k_q, dump_k_d;
  logic [2:0]           status_q, status_d;
  logic [SW-1:0]        used_addr_q, used_addr_d;

  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_status_q, out_status_d;
  logic [VALUE_W-1:0]   out_value_q, out_value_d;
  logic                 out_last_q, out_last_d;
  logic                 out_empty_q, out_empty_d;
  logic                 out_full_q, out_full_d;
  logic [TOTAL_W-1:0]   out_total_q, out_total_d;

  // ram ports
  logic [SW-1:0]        node_raddr;
  logic                 val_we;
  logic [SW-1:0]        val_waddr;
  logic [VALUE_W-1:0]   val_wdata;
  logic [VALUE_W-1:0]   val_rdata;
  logic                 link_we;
  logic [SW-1:0]        link_waddr;
  logic [SW-1:0]        link_wdata;
  logic [SW-1:0]        link_rdata;
  logic                 used_we;
  logic [SW-1:0]        used_waddr;
  logic                 used_wdata;
  logic [SW-1:0]        used_raddr;
  logic                 used_rdata;

  logic                 out_free;
  logic [SW+3:0]        count_ext;
  logic [3:0]           dump_total;
  logic                 dump_last;

  alle_ram #(.DEPTH(LIST_SLOTS), .WIDTH(VALUE_W)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (node_raddr),
    .rdata_o (val_rdata)
  );

  alle_ram #(.DEPTH(LIST_SLOTS), .WIDTH(SW)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (node_raddr),
    .rdata_o (link_rdata)
  );

  alle_ram #(.DEPTH(LIST_SLOTS), .WIDTH(1)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (used_raddr),
    .rdata_o (used_rdata)
  );

  assign out_free   = !out_valid_q || rsp_o.ready;
  assign count_ext  = {4'b0000, count_q};
  // a dump emits at most MAX_DUMP elements
  assign dump_total = (count_ext >= (SW + 4)'(MAX_DUMP)) ? MAX_DUMP : count_ext[3:0];
  assign dump_last  = (dump_k_q == 4'(dump_total - 4'd1)) || (link_rdata == HeadSlot);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    action_d     = action_q;
    key_d        = key_q;
    nv_d         = nv_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    next_d       = next_q;
    slot_d       = slot_q;
    head_d       = head_q;
    count_d      = count_q;
    dump_k_d     = dump_k_q;
    status_d     = status_q;

    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;
    out_total_d  = out_total_q;

    // hold the read address by default so stalled data stays put
    node_raddr   = cur_q;
    used_raddr   = used_addr_q;
    val_we       = 1'b0;
    val_waddr    = slot_q;
    val_wdata    = nv_q;
    link_we      = 1'b0;
    link_waddr   = slot_q;
    link_wdata   = HeadSlot;
    used_we      = 1'b0;
    used_waddr   = slot_q;
    used_wdata   = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_q;
        used_wdata = 1'b0;
        if (clr_q == LastSlot) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (req_i.valid) begin
          action_d = req_i.action;
          key_d    = req_i.key;
          nv_d     = req_i.new_value;
          case (req_i.action)
            ACT_INS_BEFORE, ACT_INS_AFTER: begin
              if (count_q == LastSlot) begin
                status_d = STAT_FULL;
                state_d  = S_RESP;
              end else if (count_q == '0) begin
                // empty list: value goes in whatever the key
                used_raddr = FirstSlot;
                state_d    = S_SCAN;
              end else begin
                node_raddr = head_q;
                cur_d      = head_q;
                prev_d     = HeadSlot;
                state_d    = S_WALK;
              end
            end
            ACT_DELETE, ACT_FIND: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
                state_d  = S_RESP;
              end else begin
                node_raddr = head_q;
                cur_d      = head_q;
                prev_d     = HeadSlot;
                state_d    = S_WALK;
              end
            end
            ACT_DUMP: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
                state_d  = S_RESP;
              end else begin
                node_raddr = head_q;
                cur_d      = head_q;
                dump_k_d   = '0;
                state_d    = S_DUMP;
              end
            end
            default: begin
              status_d = STAT_DONE;
              state_d  = S_RESP;
            end
          endcase
        end
      end

      S_WALK: begin
        if (val_rdata == key_q) begin
          next_d = link_rdata;
          case (action_q)
            ACT_INS_BEFORE, ACT_INS_AFTER: begin
              used_raddr = FirstSlot;
              state_d    = S_SCAN;
            end
            ACT_DELETE: begin
              // unlink and free the hit slot
              if (prev_q == HeadSlot) begin
                head_d = link_rdata;
              end else begin
                link_we    = 1'b1;
                link_waddr = prev_q;
                link_wdata = link_rdata;
              end
              used_we    = 1'b1;
              used_waddr = cur_q;
              used_wdata = 1'b0;
              count_d    = count_q - 1'b1;
              status_d   = STAT_DONE;
              state_d    = S_RESP;
            end
            default: begin
              status_d = STAT_FOUND;
              state_d  = S_RESP;
            end
          endcase
        end else if (link_rdata == HeadSlot) begin
          status_d = STAT_NOT_FOUND;
          state_d  = S_RESP;
        end else begin
          prev_d     = cur_q;
          cur_d      = link_rdata;
          node_raddr = link_rdata;
        end
      end

      S_SCAN: begin
        if (!used_rdata) begin
          // lowest free slot found: fill it
          slot_d     = used_addr_q;
          val_we     = 1'b1;
          val_waddr  = used_addr_q;
          val_wdata  = nv_q;
          used_we    = 1'b1;
          used_waddr = used_addr_q;
          used_wdata = 1'b1;
          link_we    = 1'b1;
          link_waddr = used_addr_q;
          if (count_q == '0) begin
            link_wdata = HeadSlot;
            head_d     = used_addr_q;
            count_d    = count_q + 1'b1;
            status_d   = STAT_DONE;
            state_d    = S_RESP;
          end else begin
            link_wdata = (action_q == ACT_INS_BEFORE) ? cur_q : next_q;
            state_d    = S_LINK;
          end
        end else if (used_addr_q == LastSlot) begin
          status_d = STAT_FULL;
          state_d  = S_RESP;
        end else begin
          used_raddr = used_addr_q + 1'b1;
        end
      end

      S_LINK: begin
        if (action_q == ACT_INS_BEFORE) begin
          if (prev_q == HeadSlot) begin
            head_d = slot_q;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_q;
            link_wdata = slot_q;
          end
        end else begin
          link_we    = 1'b1;
          link_waddr = cur_q;
          link_wdata = slot_q;
        end
        count_d  = count_q + 1'b1;
        status_d = STAT_DONE;
        state_d  = S_RESP;
      end

      S_DUMP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_DONE;
          out_value_d  = val_rdata;
          out_last_d   = dump_last;
          out_empty_d  = (count_q == '0);
          out_full_d   = (count_q == LastSlot);
          out_total_d  = count_ext[TOTAL_W-1:0];
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            dump_k_d   = dump_k_q + 4'd1;
            cur_d      = link_rdata;
            node_raddr = link_rdata;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          out_empty_d  = (count_q == '0);
          out_full_d   = (count_q == LastSlot);
          out_total_d  = count_ext[TOTAL_W-1:0];
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign used_addr_d = used_raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      head_q       <= head_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      action_q     <= action_d;
      key_q        <= key_d;
      nv_q         <= nv_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      next_q       <= next_d;
      slot_q       <= slot_d;
      dump_k_q     <= dump_k_d;
      status_q     <= status_d;
      used_addr_q  <= used_addr_d;
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
      out_empty_q  <= out_empty_d;
      out_full_q   <= out_full_d;
      out_total_q  <= out_total_d;
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.value         = out_value_q;
  assign rsp_o.last          = out_last_q;
  assign rsp_o.is_empty      = out_empty_q;
  assign rsp_o.is_full       = out_full_q;
  assign rsp_o.element_total = out_total_q;

  // a non-final result only comes from a dump that keeps going
  a_dump_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.ready && !rsp_o.last |-> state_q == S_DUMP)
    else $error("non-final result outside a dump");

  // element count and head link agree on emptiness between requests
  a_empty_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> ((count_q == '0) == (head_q == HeadSlot)))
    else $error("element count and head link disagree");

  // the free-slot scan never runs on a full list
  a_scan_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> count_q != LastSlot)
    else $error("free-slot scan on a full list");

endmodule

`default_nettype wire
